// ----- rtl/pva_pkg.sv -----
// ----------------------------------------------------------------------------
// pva_pkg: shared definitions for the polyphonic voice allocator
// Field widths, stream layout, command and register codes, sequencer types.
// ----------------------------------------------------------------------------
package pva_pkg;

   // Item field widths.
   localparam int CMD_BITS       = 3;
   localparam int KEY_BITS       = 7;
   localparam int VEL_BITS       = 7;
   localparam int TRACK_BITS     = 2;
   localparam int FIN_BITS       = 4;
   localparam int VOICE_OUT_BITS = 4;
   localparam int MASK_BITS      = 16;
   localparam int COUNT_OUT_BITS = 5;
   localparam int LISTEN_BITS    = 4;

   // Number of sequencer tracks.
   localparam int TRACK_COUNT = 4;

   // Stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 32;

   // Input data layout, lowest bit first.
   localparam int REQ_NOTE_LSB  = 0;
   localparam int REQ_VEL_LSB   = REQ_NOTE_LSB + KEY_BITS;
   localparam int REQ_TRACK_LSB = REQ_VEL_LSB + VEL_BITS;
   localparam int REQ_FIN_LSB   = REQ_TRACK_LSB + TRACK_BITS;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_LISTENING = 1'b0;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_NOTE_ON        = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_NOTE_OFF       = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_TRACK_NOTE_ON  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_TRACK_NOTE_OFF = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_VOICE_FINISHED = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_COMMIT = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ALLOC,
      OP_RELEASE,
      OP_FINISH
   } op_type;

endpackage

// ----- rtl/pva_ram.sv -----
// ----------------------------------------------------------------------------
// pva_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/poly_voice_allocator.sv -----
// ----------------------------------------------------------------------------
// poly_voice_allocator: voice allocation for a polyphonic synthesizer
// Assigns voices to note-on items, releases voices on note-off items and
// retires voices when their envelope ends, with oldest-note stealing.
// ----------------------------------------------------------------------------
// A note-on takes the lowest inactive voice; when all voices are active it
// steals the releasing voice with the oldest start stamp, or else the oldest
// held voice, with ties going to the lower voice index. Every allocation
// stamps the voice from a running counter that wraps at STAMP_BITS. A
// note-off sends every active voice holding that note to release. A track
// note-on allocates only when the track's bit in the listening_tracks
// register is set, and a track note-off releases the note on all voices. A
// voice-finished item makes that voice inactive. Each item produces exactly
// one result item. Voice notes and stamps live in one RAM with a registered
// read, and a single sequencer sweeps it one voice per cycle through one
// shared stamp comparator. The result sits in an output register, so a new
// item is accepted while the previous result waits.
// ----------------------------------------------------------------------------
module poly_voice_allocator #(
   parameter int VOICE_COUNT = 16,
   parameter int STAMP_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // note [6:0], velocity [13:7], track [15:14], finished_voice [19:16]
   input  logic [pva_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // command [2:0]
   input  logic [pva_pkg::CMD_BITS-1:0]       req_tuser,
   // Result items.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // assigned [0], assigned_voice [4:1], stolen [5], released_mask [21:6],
   // active_count [26:22]
   output logic [pva_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pva_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pva_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pva_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   import pva_pkg::*;

   localparam int IDX_W   = $clog2(VOICE_COUNT);
   localparam int CNT_W   = $clog2(VOICE_COUNT + 1);
   localparam int ENTRY_W = KEY_BITS + STAMP_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);
   localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(VOICE_COUNT);

   // Sequencer and item registers.
   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [KEY_BITS-1:0]        note_ff, note_in;
   logic [IDX_W-1:0]           fin_idx_ff, fin_idx_in;

   // Sweep counter and the voice whose RAM data arrives this cycle.
   logic [IDX_W:0]             cnt_ff, cnt_in;
   logic                       proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]           proc_idx_ff, proc_idx_in;

   // Candidates collected during the sweep.
   logic                       free_found_ff, free_found_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic                       rel_found_ff, rel_found_in;
   logic [IDX_W-1:0]           rel_idx_ff, rel_idx_in;
   logic [STAMP_BITS-1:0]      rel_best_ff, rel_best_in;
   logic                       held_found_ff, held_found_in;
   logic [IDX_W-1:0]           held_idx_ff, held_idx_in;
   logic [STAMP_BITS-1:0]      held_best_ff, held_best_in;

   // Result under construction.
   logic                       res_assigned_ff, res_assigned_in;
   logic [IDX_W-1:0]           res_voice_ff, res_voice_in;
   logic                       res_stolen_ff, res_stolen_in;
   logic [MASK_BITS-1:0]       mask_ff, mask_in;

   // Voice state held in flip-flops.
   logic [VOICE_COUNT-1:0]     voice_on_ff, voice_on_in;
   logic [VOICE_COUNT-1:0]     voice_rel_ff, voice_rel_in;
   logic [CNT_W-1:0]           active_count_ff, active_count_in;
   logic [STAMP_BITS-1:0]      stamp_ctr_ff, stamp_ctr_in;
   logic [LISTEN_BITS-1:0]     listening_ff, listening_in;

   // Output register.
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // Item fields.
   logic [KEY_BITS-1:0]        req_note;
   logic [TRACK_BITS-1:0]      req_track;
   logic [FIN_BITS-1:0]        req_fin;
   logic                       req_accept;
   logic                       track_ok;

   // Voice RAM ports and sweep datapath.
   logic                       ram_wr_en;
   logic [IDX_W-1:0]           pick_idx;
   logic [ENTRY_W-1:0]         ram_rd_data;
   logic [KEY_BITS-1:0]        rd_key;
   logic [STAMP_BITS-1:0]      rd_stamp;
   logic                       cur_on;
   logic                       cur_rel;
   logic                       cat_found;
   logic [STAMP_BITS-1:0]      cat_best;
   logic                       stamp_older;
   logic                       csr_write;

   assign req_note   = req_tdata[REQ_NOTE_LSB +: KEY_BITS];
   assign req_track  = req_tdata[REQ_TRACK_LSB +: TRACK_BITS];
   assign req_fin    = req_tdata[REQ_FIN_LSB +: FIN_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign track_ok   = (32'(req_track) < TRACK_COUNT);

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == REG_LISTENING)
                       ? CSR_DATA_BITS'(listening_ff) : '0;

   assign rd_key   = ram_rd_data[STAMP_BITS +: KEY_BITS];
   assign rd_stamp = ram_rd_data[STAMP_BITS-1:0];
   assign cur_on   = voice_on_ff[proc_idx_ff];
   assign cur_rel  = voice_rel_ff[proc_idx_ff];

   // The one stamp comparator serves whichever group the current voice is in.
   assign cat_found   = cur_rel ? rel_found_ff : held_found_ff;
   assign cat_best    = cur_rel ? rel_best_ff : held_best_ff;
   assign stamp_older = (rd_stamp < cat_best);

   // Victim choice: a free voice first, then the oldest releasing one, then
   // the oldest held one.
   always_comb begin
      priority if (free_found_ff) begin
         pick_idx = free_idx_ff;
      end else if (rel_found_ff) begin
         pick_idx = rel_idx_ff;
      end else begin
         pick_idx = held_idx_ff;
      end
   end

   assign ram_wr_en = (state_ff == ST_COMMIT);

   pva_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VOICE_COUNT)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_idx),
      .wr_data ({note_ff, stamp_ctr_ff}),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      note_in         = note_ff;
      fin_idx_in      = fin_idx_ff;
      cnt_in          = cnt_ff;
      proc_valid_in   = 1'b0;
      proc_idx_in     = cnt_ff[IDX_W-1:0];
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      rel_found_in    = rel_found_ff;
      rel_idx_in      = rel_idx_ff;
      rel_best_in     = rel_best_ff;
      held_found_in   = held_found_ff;
      held_idx_in     = held_idx_ff;
      held_best_in    = held_best_ff;
      res_assigned_in = res_assigned_ff;
      res_voice_in    = res_voice_ff;
      res_stolen_in   = res_stolen_ff;
      mask_in         = mask_ff;
      voice_on_in     = voice_on_ff;
      voice_rel_in    = voice_rel_ff;
      active_count_in = active_count_ff;
      stamp_ctr_in    = stamp_ctr_ff;
      listening_in    = listening_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in    = rsp_tdata_ff;

      if (csr_write && (csr_paddr[CSR_ADDR_BITS-1] == REG_LISTENING)) begin
         listening_in = csr_pwdata[LISTEN_BITS-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               note_in         = req_note;
               fin_idx_in      = IDX_W'(req_fin);
               cnt_in          = '0;
               free_found_in   = 1'b0;
               free_idx_in     = '0;
               rel_found_in    = 1'b0;
               rel_idx_in      = '0;
               held_found_in   = 1'b0;
               held_idx_in     = '0;
               res_assigned_in = 1'b0;
               res_voice_in    = '0;
               res_stolen_in   = 1'b0;
               mask_in         = '0;
               op_in           = OP_NONE;
               unique case (req_tuser)
                  CMD_NOTE_ON: begin
                     op_in = OP_ALLOC;
                  end
                  CMD_NOTE_OFF: begin
                     op_in = OP_RELEASE;
                  end
                  CMD_TRACK_NOTE_ON: begin
                     if (track_ok && listening_ff[req_track]) begin
                        op_in = OP_ALLOC;
                     end
                  end
                  CMD_TRACK_NOTE_OFF: begin
                     if (track_ok) begin
                        op_in = OP_RELEASE;
                     end
                  end
                  CMD_VOICE_FINISHED: begin
                     if (32'(req_fin) < VOICE_COUNT) begin
                        op_in = OP_FINISH;
                     end
                  end
                  default: begin
                     op_in = OP_NONE;
                  end
               endcase
               unique case (op_in)
                  OP_ALLOC,
                  OP_RELEASE: state_in = ST_SCAN;
                  OP_FINISH:  state_in = ST_FINISH;
                  default:    state_in = ST_RESULT;
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one RAM read per cycle; its data is examined in the next cycle.
            if (cnt_ff < SCAN_END) begin
               proc_valid_in = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
            end
            if (proc_valid_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (!cur_on && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = proc_idx_ff;
                  end
                  if (cur_on && (!cat_found || stamp_older)) begin
                     if (cur_rel) begin
                        rel_found_in = 1'b1;
                        rel_idx_in   = proc_idx_ff;
                        rel_best_in  = rd_stamp;
                     end else begin
                        held_found_in = 1'b1;
                        held_idx_in   = proc_idx_ff;
                        held_best_in  = rd_stamp;
                     end
                  end
               end else if (cur_on && (rd_key == note_ff)) begin
                  voice_rel_in[proc_idx_ff] = 1'b1;
                  // Only voices 0 to 15 have a bit in the released mask.
                  mask_in = mask_ff | (MASK_BITS'(1) << proc_idx_ff);
               end
               if (proc_idx_ff == LAST_IDX) begin
                  state_in = (op_ff == OP_ALLOC) ? ST_COMMIT : ST_RESULT;
               end
            end
         end

         ST_COMMIT: begin
            res_assigned_in        = 1'b1;
            res_voice_in           = pick_idx;
            res_stolen_in          = !free_found_ff;
            voice_on_in[pick_idx]  = 1'b1;
            voice_rel_in[pick_idx] = 1'b0;
            stamp_ctr_in           = stamp_ctr_ff + 1'b1;
            if (free_found_ff) begin
               active_count_in = active_count_ff + 1'b1;
            end
            state_in = ST_RESULT;
         end

         ST_FINISH: begin
            if (voice_on_ff[fin_idx_ff]) begin
               active_count_in = active_count_ff - 1'b1;
            end
            voice_on_in[fin_idx_ff]  = 1'b0;
            voice_rel_in[fin_idx_ff] = 1'b0;
            state_in                 = ST_RESULT;
         end

         ST_RESULT: begin
            // Hand the result over once the output register is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'b0,
                                COUNT_OUT_BITS'(active_count_ff),
                                mask_ff,
                                res_stolen_ff,
                                VOICE_OUT_BITS'(res_voice_ff),
                                res_assigned_ff};
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         proc_valid_ff   <= 1'b0;
         voice_on_ff     <= '0;
         voice_rel_ff    <= '0;
         active_count_ff <= '0;
         stamp_ctr_ff    <= '0;
         listening_ff    <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         proc_valid_ff   <= proc_valid_in;
         voice_on_ff     <= voice_on_in;
         voice_rel_ff    <= voice_rel_in;
         active_count_ff <= active_count_in;
         stamp_ctr_ff    <= stamp_ctr_in;
         listening_ff    <= listening_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      note_ff         <= note_in;
      fin_idx_ff      <= fin_idx_in;
      cnt_ff          <= cnt_in;
      proc_idx_ff     <= proc_idx_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      rel_found_ff    <= rel_found_in;
      rel_idx_ff      <= rel_idx_in;
      rel_best_ff     <= rel_best_in;
      held_found_ff   <= held_found_in;
      held_idx_ff     <= held_idx_in;
      held_best_ff    <= held_best_in;
      res_assigned_ff <= res_assigned_in;
      res_voice_ff    <= res_voice_in;
      res_stolen_ff   <= res_stolen_in;
      mask_ff         <= mask_in;
      rsp_tdata_ff    <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The running count must always match the number of active voices.
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      32'(active_count_ff) == $countones(voice_on_ff))
      else $error("active voice count out of step with voice state");

   // Only an active voice can be in its release phase.
   a_release_needs_on: assert property (@(posedge clock) disable iff (reset)
      (voice_rel_ff & ~voice_on_ff) == '0)
      else $error("inactive voice marked as releasing");

   // An allocation leaves the chosen voice active and held.
   a_commit_sets_voice: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |=>
         voice_on_ff[$past(pick_idx)] && !voice_rel_ff[$past(pick_idx)])
      else $error("allocated voice not left active and held");

endmodule
